@@ hw/rtl/per_source_flow_statistics_unit_assert.svh @@
// Assertion macros shared by the flow statistics RTL.
`ifndef PER_SOURCE_FLOW_STATISTICS_UNIT_ASSERT_SVH
`define PER_SOURCE_FLOW_STATISTICS_UNIT_ASSERT_SVH
// same-cycle implication, checked out of reset
`define PFS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flow statistics check failed");
// next-cycle implication, checked out of reset
`define PFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flow statistics check failed");
`endif

@@ hw/rtl/pfs_pkg.sv @@
// Types and constants of the per-source flow statistics unit.
package pfs_pkg;
  localparam int ID_W   = 16;
  localparam int TIME_W = 32;
  localparam int SUM_W  = 48;
  localparam int AVG_W  = 40;
  localparam int DVD_W  = 66;
  localparam int DVS_W  = 42;

  localparam logic [1:0] CMD_RECORD    = 2'd0;
  localparam logic [1:0] CMD_QUERY_ONE = 2'd1;
  localparam logic [1:0] CMD_QUERY_ALL = 2'd2;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  localparam logic [2:0] ST_RECORDED = 3'd0;
  localparam logic [2:0] ST_WARM_UP  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_QUERY_OK = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;

  localparam logic CFG_WARM_UP    = 1'b0;
  localparam logic CFG_RESET_TIME = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   src_id;
    logic              is_request;
    logic [TIME_W-1:0] rx_time;
    logic [TIME_W-1:0] send_time;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      packets;
    logic [31:0]      flits;
    logic             delay_valid;
    logic [AVG_W-1:0] avg_delay;
    logic [31:0]      max_delay;
    logic [31:0]      throughput;
    logic [6:0]       sources_seen;
  } out_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]   src;
    logic [31:0]       packets;
    logic [31:0]       flits;
    logic [SUM_W-1:0]  sum;
    logic [31:0]       peak;
    logic [TIME_W-1:0] last;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;
endpackage

@@ hw/rtl/pfs_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module pfs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pfs_pkg::div_req_t req,
  output pfs_pkg::div_rsp_t rsp
);
  localparam int DVD_W  = pfs_pkg::DVD_W;
  localparam int DVS_W  = pfs_pkg::DVS_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0]  rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DVS_W:0]    sh, diff;
  logic              ge;

  always_comb begin
    sh       = {rem_r, quo_r[DVD_W-1]};
    diff     = sh - {1'b0, dvs_r};
    ge       = sh >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      step_nxt = STEP_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

@@ hw/rtl/per_source_flow_statistics_unit.sv @@
// Per-source flow statistics: source table, sequencer and result register.
// Warm-up beats and unused commands go straight to the result register; a record searches
// the table entry by entry, then updates the hit entry, allocates a new one or reports full.
// Query one searches for the source, then runs up to two divisions. Query aggregate runs up to
// one division per allocated entry and one for the average; one beat in flight, input stalled
// until its result is loaded. Sync active-low reset empties table, clears config.
module per_source_flow_statistics_unit #(
  parameter int NUM_SOURCES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfs_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  `include "per_source_flow_statistics_unit_assert.svh"

  localparam int IW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CW    = $clog2(NUM_SOURCES + 1);
  localparam int PK_W  = 32 + IW;
  localparam int SM_W  = pfs_pkg::SUM_W + IW;
  localparam int DVD_W = pfs_pkg::DVD_W;
  localparam int DVS_W = pfs_pkg::DVS_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RD     = 10'b0000000010,
    S_CHK    = 10'b0000000100,
    S_REC    = 10'b0000001000,
    S_TP     = 10'b0000010000,
    S_TPDIV  = 10'b0000100000,
    S_ACC    = 10'b0001000000,
    S_AVG    = 10'b0010000000,
    S_AVGDIV = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      k_r, k_nxt, cnt_r, cnt_nxt;
  logic [31:0]        warm_r, rtime_r;
  logic               hit_r, hit_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [15:0]        id_r, id_nxt;
  logic               req_r, req_nxt;
  logic [31:0]        arr_r, arr_nxt, snd_r, snd_nxt;
  logic [2:0]         st_r, st_nxt;
  logic [PK_W-1:0]    pk_r, pk_nxt, fl_r, fl_nxt;
  logic [SM_W-1:0]    sum_r, sum_nxt;
  logic [31:0]        mx_r, mx_nxt, tp_r, tp_nxt, tpe_r, tpe_nxt;
  logic [39:0]        avg_r, avg_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfs_pkg::out_beat_t out_r, out_nxt;

  pfs_pkg::entry_t    mem [NUM_SOURCES];
  pfs_pkg::entry_t    rd_r, base, wdata;
  logic               rd_en, wr_en;
  logic [IW-1:0]      waddr;
  logic [31:0]        d;
  logic [48:0]        s49;
  logic [32:0]        tps;
  pfs_pkg::div_req_t  div_req;
  pfs_pkg::div_rsp_t  div_rsp;

  pfs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    base      = rd_r;
    if (!hit_r) begin
      base     = '0;
      base.src = id_r;
    end
    d     = (arr_r > snd_r) ? arr_r - snd_r : 32'd0;
    s49   = {1'b0, base.sum} + 49'(d);
    wdata = base;
    if (req_r) begin
      if (base.packets != 32'hFFFFFFFF) wdata.packets = base.packets + 32'd1;
      wdata.sum = s49[48] ? {48{1'b1}} : s49[47:0];
      if (d > base.peak) wdata.peak = d;
    end
    if (base.flits != 32'hFFFFFFFF) wdata.flits = base.flits + 32'd1;
    wdata.last = arr_r - warm_r;
    wdata.src  = id_r;
    waddr      = hit_r ? k_r[IW-1:0] : cnt_r[IW-1:0];
    tps        = {1'b0, tp_r} + {1'b0, tpe_r};
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    req_nxt       = req_r;
    arr_nxt       = arr_r;
    snd_nxt       = snd_r;
    st_nxt        = st_r;
    pk_nxt        = pk_r;
    fl_nxt        = fl_r;
    sum_nxt       = sum_r;
    mx_nxt        = mx_r;
    tp_nxt        = tp_r;
    tpe_nxt       = tpe_r;
    avg_nxt       = avg_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & out_stall;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    div_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data.cmd;
          id_nxt  = in_data.src_id;
          req_nxt = in_data.is_request;
          arr_nxt = in_data.rx_time;
          snd_nxt = in_data.send_time;
          k_nxt   = '0;
          hit_nxt = 1'b0;
          pk_nxt  = '0;
          fl_nxt  = '0;
          sum_nxt = '0;
          mx_nxt  = '0;
          tp_nxt  = '0;
          tpe_nxt = '0;
          avg_nxt = '0;
          st_nxt  = pfs_pkg::ST_QUERY_OK;
          unique case (in_data.cmd)
            pfs_pkg::CMD_RECORD: begin
              if ({1'b0, in_data.rx_time} < {1'b0, rtime_r} + {1'b0, warm_r}) begin
                st_nxt    = pfs_pkg::ST_WARM_UP;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_RD;
              end
            end
            pfs_pkg::CMD_QUERY_ONE, pfs_pkg::CMD_QUERY_ALL: state_nxt = S_RD;
            default: begin
              st_nxt    = pfs_pkg::ST_UNKNOWN;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_RD: begin
        if (k_r < cnt_r) begin
          rd_en     = 1'b1;
          state_nxt = S_CHK;
        end else if (cmd_r == pfs_pkg::CMD_QUERY_ALL) begin
          state_nxt = S_AVG;
        end else if (cmd_r == pfs_pkg::CMD_QUERY_ONE) begin
          st_nxt    = pfs_pkg::ST_UNKNOWN;
          state_nxt = S_OUT;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = S_REC;
        end
      end
      S_CHK: begin
        if (cmd_r == pfs_pkg::CMD_QUERY_ALL ||
            (cmd_r == pfs_pkg::CMD_QUERY_ONE && rd_r.src == id_r)) begin
          pk_nxt  = pk_r + PK_W'(rd_r.packets);
          fl_nxt  = fl_r + PK_W'(rd_r.flits);
          sum_nxt = sum_r + SM_W'(rd_r.sum);
          if (rd_r.packets != 32'd0 && rd_r.peak > mx_r) mx_nxt = rd_r.peak;
          state_nxt = S_TP;
        end else if (cmd_r == pfs_pkg::CMD_RECORD && rd_r.src == id_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_REC;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_RD;
        end
      end
      S_REC: begin
        if (!hit_r && cnt_r >= CW'(NUM_SOURCES)) begin
          st_nxt = pfs_pkg::ST_FULL;
        end else begin
          wr_en  = 1'b1;
          st_nxt = pfs_pkg::ST_RECORDED;
          if (!hit_r) cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = S_OUT;
      end
      S_TP: begin
        if (rd_r.flits == 32'd0) begin
          tpe_nxt   = '0;
          state_nxt = S_ACC;
        end else if (rd_r.last == 32'd0) begin
          tpe_nxt   = 32'hFFFFFFFF;
          state_nxt = S_ACC;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'({rd_r.flits, 16'h0000});
          div_req.divisor  = DVS_W'(rd_r.last);
          state_nxt        = S_TPDIV;
        end
      end
      S_TPDIV: begin
        if (div_rsp.done) begin
          tpe_nxt   = (|div_rsp.quotient[DVD_W-1:32]) ? 32'hFFFFFFFF
                                                      : div_rsp.quotient[31:0];
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        tp_nxt = tps[32] ? 32'hFFFFFFFF : tps[31:0];
        if (cmd_r == pfs_pkg::CMD_QUERY_ALL) begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_RD;
        end else begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        if (pk_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'({sum_r, 8'h00});
          div_req.divisor  = DVS_W'(pk_r);
          state_nxt        = S_AVGDIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_AVGDIV: begin
        if (div_rsp.done) begin
          avg_nxt   = div_rsp.quotient[39:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.status       = st_r;
          out_nxt.packets      = (|pk_r[PK_W-1:32]) ? 32'hFFFFFFFF : pk_r[31:0];
          out_nxt.flits        = (|fl_r[PK_W-1:32]) ? 32'hFFFFFFFF : fl_r[31:0];
          out_nxt.delay_valid  = pk_r != '0;
          out_nxt.avg_delay    = avg_r;
          out_nxt.max_delay    = mx_r;
          out_nxt.throughput   = tp_r;
          out_nxt.sources_seen = 7'(cnt_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      warm_r      <= '0;
      rtime_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == pfs_pkg::CFG_WARM_UP)    warm_r  <= cfg_data;
      if (cfg_we && cfg_index == pfs_pkg::CFG_RESET_TIME) rtime_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    hit_r <= hit_nxt;
    cmd_r <= cmd_nxt;
    id_r  <= id_nxt;
    req_r <= req_nxt;
    arr_r <= arr_nxt;
    snd_r <= snd_nxt;
    st_r  <= st_nxt;
    pk_r  <= pk_nxt;
    fl_r  <= fl_nxt;
    sum_r <= sum_nxt;
    mx_r  <= mx_nxt;
    tp_r  <= tp_nxt;
    tpe_r <= tpe_nxt;
    avg_r <= avg_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[k_r[IW-1:0]];
    if (wr_en) mem[waddr] <= wdata;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PFS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(NUM_SOURCES))
  `PFS_ASSERT_NEXT(a_wr_in_table, wr_en, CW'($past(waddr)) < cnt_r)
  `PFS_ASSERT_IMPL(a_div_idle, div_req.start, !div_rsp.busy)
  `PFS_ASSERT_IMPL(a_status_range, $rose(out_valid_r), out_r.status <= pfs_pkg::ST_UNKNOWN)
endmodule
